FILE: rtl/assert_macros.svh
// Assertion macros shared by the calculator RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: rtl/kfc_pkg.sv
// Package for the keypad calculator: key codes, modes, command and status types.
// No dependencies.
package kfc_pkg;
   localparam int unsigned DataWidth = 32;
   localparam logic [7:0] KeyPlus  = 8'h2b;
   localparam logic [7:0] KeyMinus = 8'h2d;
   localparam logic [7:0] KeyMul   = 8'h2a;
   localparam logic [7:0] KeyDiv   = 8'h25;
   localparam logic [7:0] KeyEqual = 8'h3d;
   localparam logic [7:0] KeyClear = 8'd13;
   localparam logic [7:0] DigitLimit = 8'd10;
   localparam logic [7:0] AsciiZero = 8'd48;

   localparam logic [1:0] ModeSign    = 2'd0;
   localparam logic [1:0] ModeOperand = 2'd1;
   localparam logic [1:0] ModeResult  = 2'd2;

   localparam logic [1:0] ErrNone    = 2'd0;
   localparam logic [1:0] ErrDivZero = 2'd1;
   localparam logic [1:0] ErrBadKey  = 2'd2;

   // Datapath commands issued by the controller.
   typedef struct packed {
      logic       clear;      // reset all datapath state
      logic       apply;      // apply pending op (non-divide)
      logic       div_start;  // start the iterative divider
      logic       div_step;   // one divider iteration
      logic       div_finish; // write signed quotient to accumulator
      logic       digit_acc;  // operand = operand*10 +/- key
      logic       digit_new;  // operand = +/- key (sign entry)
      logic       digit_fresh;// accumulator = 0, operand = key (result mode)
      logic       set_op;     // pending_op = key, operand and sign to zero
      logic       set_neg;    // sign = negative
      logic [7:0] key;
   } cmd_type;

   typedef struct packed {
      logic       pend_div;  // pending op is divide
      logic       b_zero;    // operand is zero
      logic       sign_neg;  // sign seen
      logic       div_done;  // divider finished its iterations
   } status_type;
endpackage

FILE: rtl/kfc_datapath.sv
// Datapath of the keypad calculator: accumulator, operand, pending op and
// a radix-2 restoring divider. Depends on kfc_pkg.
module kfc_datapath
   import kfc_pkg::*;
#(
   parameter int unsigned Width = DataWidth
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   output logic [Width-1:0] total
);
   localparam int unsigned CntWidth = $clog2(Width + 1);

   logic [Width-1:0] acc_ff, acc_in, opnd_ff, opnd_in;
   logic             neg_ff, neg_in;
   logic [7:0]       op_ff, op_in;
   logic [Width-1:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic             qneg_ff, qneg_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic [Width:0]   trial;
   logic [Width-1:0] key_ext, times10;

   assign key_ext = Width'(cmd.key);
   assign times10 = (opnd_ff << 3) + (opnd_ff << 1);
   assign trial   = {rem_ff, quo_ff[Width-1]} - {1'b0, dvs_ff};

   always_comb begin
      acc_in = acc_ff; opnd_in = opnd_ff; neg_in = neg_ff; op_in = op_ff;
      rem_in = rem_ff; quo_in = quo_ff; dvs_in = dvs_ff; qneg_in = qneg_ff;
      cnt_in = cnt_ff;
      if (cmd.clear) begin
         acc_in = '0; opnd_in = '0; neg_in = 1'b0; op_in = KeyPlus;
      end else if (cmd.digit_fresh) begin
         acc_in = '0; opnd_in = key_ext; neg_in = 1'b0; op_in = KeyPlus;
      end else if (cmd.digit_acc) begin
         opnd_in = neg_ff ? times10 - key_ext : times10 + key_ext;
      end else if (cmd.digit_new) begin
         opnd_in = neg_ff ? '0 - key_ext : key_ext;
      end else if (cmd.set_neg) begin
         neg_in = 1'b1;
      end else if (cmd.set_op) begin
         op_in = cmd.key; opnd_in = '0; neg_in = 1'b0;
      end else if (cmd.apply) begin
         case (op_ff)
            KeyPlus:  acc_in = acc_ff + opnd_ff;
            KeyMinus: acc_in = acc_ff - opnd_ff;
            KeyMul:   acc_in = acc_ff * opnd_ff;
            default:  acc_in = acc_ff;
         endcase
      end else if (cmd.div_start) begin
         rem_in  = '0;
         quo_in  = acc_ff[Width-1] ? '0 - acc_ff : acc_ff;
         dvs_in  = opnd_ff[Width-1] ? '0 - opnd_ff : opnd_ff;
         qneg_in = acc_ff[Width-1] ^ opnd_ff[Width-1];
         cnt_in  = CntWidth'(Width);
      end else if (cmd.div_step) begin
         if (!trial[Width]) begin
            rem_in = trial[Width-1:0];
            quo_in = {quo_ff[Width-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[Width-2:0], quo_ff[Width-1]};
            quo_in = {quo_ff[Width-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end else if (cmd.div_finish) begin
         acc_in = qneg_ff ? '0 - quo_ff : quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0; opnd_ff <= '0; neg_ff <= 1'b0; op_ff <= KeyPlus;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in; opnd_ff <= opnd_in; neg_ff <= neg_in; op_ff <= op_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; dvs_ff <= dvs_in; qneg_ff <= qneg_in;
   end

   assign status.pend_div = (op_ff == KeyDiv);
   assign status.b_zero   = (opnd_ff == '0);
   assign status.sign_neg = neg_ff;
   assign status.div_done = (cnt_ff == '0);
   assign total = acc_ff;
endmodule

FILE: rtl/kfc_control.sv
// Controller of the keypad calculator: key decode, entry mode and handshake.
// Depends on kfc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module kfc_control
   import kfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       key_valid,
   output logic       key_ready,
   input  logic [7:0] key,
   output logic       rsp_load,
   output logic [1:0] rsp_err,
   output logic       rsp_upd,
   output logic       rsp_echo,
   output logic [7:0] rsp_char,
   output logic       rsp_clr,
   input  logic       rsp_free,
   output cmd_type    cmd,
   input  status_type status
);
   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StDiv  = 2'd1;
   localparam logic [1:0] StFin  = 2'd2;

   logic [1:0] state_ff, state_in, mode_ff, mode_in;
   logic [7:0] key_ff, key_in;
   logic       accept, is_digit, is_eq;

   assign key_ready = (state_ff == StIdle) && rsp_free;
   assign accept    = key_valid && key_ready;
   assign is_digit  = key < DigitLimit;
   assign is_eq     = key == KeyEqual;

   always_comb begin
      state_in = state_ff; mode_in = mode_ff; key_in = key_ff;
      cmd = '0; cmd.key = key;
      rsp_load = 1'b0; rsp_err = ErrNone; rsp_upd = 1'b0;
      rsp_echo = 1'b0; rsp_clr = 1'b0;
      rsp_char = is_digit ? key + AsciiZero : key;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               if (key == KeyClear) begin
                  cmd.clear = 1'b1; rsp_clr = 1'b1; rsp_load = 1'b1;
                  mode_in = ModeSign;
               end else if (mode_ff == ModeOperand) begin
                  if (is_digit) begin
                     cmd.digit_acc = 1'b1; rsp_echo = 1'b1; rsp_load = 1'b1;
                  end else if (status.pend_div) begin
                     if (status.b_zero) begin
                        cmd.clear = 1'b1; rsp_clr = 1'b1; rsp_err = ErrDivZero;
                        rsp_load = 1'b1; mode_in = ModeSign;
                     end else begin
                        cmd.div_start = 1'b1; key_in = key; state_in = StDiv;
                     end
                  end else begin
                     cmd.apply = 1'b1; rsp_upd = 1'b1; rsp_echo = !is_eq;
                     rsp_load = 1'b1; state_in = StFin; key_in = key;
                  end
               end else if (mode_ff == ModeResult) begin
                  if (is_digit) begin
                     cmd.digit_fresh = 1'b1; mode_in = ModeOperand;
                  end else begin
                     cmd.set_op = 1'b1; mode_in = is_eq ? ModeResult : ModeSign;
                  end
                  rsp_echo = !is_eq; rsp_load = 1'b1;
               end else begin
                  if (is_digit) begin
                     cmd.digit_new = 1'b1; mode_in = ModeOperand;
                     rsp_echo = 1'b1; rsp_load = 1'b1;
                  end else if (key == KeyMinus && !status.sign_neg) begin
                     cmd.set_neg = 1'b1; rsp_echo = 1'b1; rsp_load = 1'b1;
                  end else begin
                     cmd.clear = 1'b1; rsp_clr = 1'b1; rsp_err = ErrBadKey;
                     rsp_load = 1'b1; mode_in = ModeSign;
                  end
               end
            end
         end
         StDiv: begin
            cmd.key = key_ff;
            if (status.div_done) begin
               cmd.div_finish = 1'b1; state_in = StFin;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         StFin: begin
            // Accumulator is final; store the new pending op and respond.
            cmd.key = key_ff; cmd.set_op = 1'b1; state_in = StIdle;
            mode_in = (key_ff == KeyEqual) ? ModeResult : ModeSign;
            rsp_load = 1'b1; rsp_upd = 1'b1; rsp_echo = key_ff != KeyEqual;
            rsp_char = key_ff;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle; mode_ff <= ModeSign;
      end else begin
         state_ff <= state_in; mode_ff <= mode_in;
      end
      key_ff <= key_in;
   end

   // An apply response in idle is replaced by the one from the finish state.
   logic rsp_load_q;
   assign rsp_load_q = rsp_load && !(state_ff == StIdle && state_in == StFin);

   `ASSERT_IMPLY(a_div_only_nonzero, clock, reset, cmd.div_start, !status.b_zero)
   `ASSERT_NEXT(a_fin_returns, clock, reset, state_ff == StFin, state_ff == StIdle)
   `ASSERT_IMPLY(a_no_accept_busy, clock, reset, state_ff != StIdle, !key_ready)
   `ASSERT_IMPLY(a_load_once, clock, reset, rsp_load_q, !(cmd.div_start))
endmodule

FILE: rtl/keypad_four_function_calculator_core.sv
// Top level of the keypad calculator; joins kfc_control and kfc_datapath.
// Depends on kfc_pkg, kfc_control and kfc_datapath.
//
// The core takes one key code per transfer and returns one result per key.
// These keys are answered straight from the idle state: digit keys, sign
// keys, clear, keys in showing-result mode, bad keys and divide by zero.
// Keys that apply a pending '+', '-', '*' or unknown operator are answered
// from the finish state. A divide passes through the divide state and then
// the finish state; it runs on the radix-2 restoring divider, which retires
// one quotient bit per cycle over Width iterations. One key is in work at a
// time. A new key is accepted only when the controller is idle, no result is
// on its way into the output register, and that register is empty or its
// result is being taken in the same cycle.
module keypad_four_function_calculator_core
   import kfc_pkg::*;
#(
   parameter int unsigned Width = DataWidth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] key
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [Width-1:0] total, [Width] total_updated, [Width+2:Width+1] error_code,
   // [Width+10:Width+3] echo_char, [Width+11] echo_valid, [Width+12] cleared,
   // [Width+15:Width+13] zero
   output logic [Width+15:0] rsp_tdata
);
   cmd_type    cmd;
   status_type status;
   logic       load, upd, echo, clr, vld_ff, vld_in, pend_ff, pend_in;
   logic [1:0] err;
   logic [7:0] chr;
   logic [Width-1:0] total;
   logic [12:0] meta_ff, meta_in;
   logic       free;

   // The output register can take a new result when none is on its way in
   // and it is empty or being drained this cycle.
   assign free = !pend_ff && (!vld_ff || rsp_tready);

   kfc_control u_ctrl (
      .clock, .reset,
      .key_valid(req_tvalid), .key_ready(req_tready), .key(req_tdata),
      .rsp_load(load), .rsp_err(err), .rsp_upd(upd), .rsp_echo(echo),
      .rsp_char(chr), .rsp_clr(clr), .rsp_free(free),
      .cmd, .status
   );

   kfc_datapath #(.Width(Width)) u_dp (
      .clock, .reset, .cmd, .status, .total
   );

   // A load in the idle state that starts an apply is only a marker; the
   // real result comes from the finish state in the next cycle. A result is
   // registered in the pending flag and then in the valid flag, once the
   // accumulator is final. The accumulator then holds until the result is taken,
   // since no key is accepted before that.
   assign pend_in = load && !cmd.apply;
   assign meta_in = {clr, echo, echo ? chr : 8'd0, err, upd};
   assign vld_in  = pend_ff || (vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in; pend_ff <= pend_in;
      end
      if (pend_in) meta_ff <= meta_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {3'b000, meta_ff, total};
endmodule
